### hw/rtl/dtd_pkg.sv
// shared types and constants of the task dispatcher
`default_nettype none
package dtd_pkg;

   localparam int TASK_SLOTS_DEF = 32;
   localparam int WORKERS_DEF    = 8;

   localparam int TASK_W     = 5;
   localparam int WORKER_W   = 3;
   localparam int KIND_W     = 4;
   localparam int REQ_W      = 3;
   localparam int OC_W       = 6;
   localparam int CNT_W      = 4;
   localparam int CAP_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [OC_W-1:0]  OC_MAX    = 6'd63;
   localparam logic [CNT_W-1:0] WCNT_RST  = 4'd8;
   localparam logic [CAP_W-1:0] WCAP_RST  = 6'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORKER_CAPACITY = 2'd1;

   localparam logic [KIND_W-1:0] RES_ALLOCATED = 4'd0;
   localparam logic [KIND_W-1:0] RES_NO_SLOT   = 4'd1;
   localparam logic [KIND_W-1:0] RES_ASSIGNED  = 4'd2;
   localparam logic [KIND_W-1:0] RES_CHAIN     = 4'd3;
   localparam logic [KIND_W-1:0] RES_PICKED    = 4'd4;
   localparam logic [KIND_W-1:0] RES_NONE      = 4'd5;
   localparam logic [KIND_W-1:0] RES_ACK       = 4'd6;
   localparam logic [KIND_W-1:0] RES_REFUSED   = 4'd7;
   localparam logic [KIND_W-1:0] RES_PASS_END  = 4'd8;

   typedef enum logic [REQ_W-1:0] {
      REQ_ALLOC    = 3'd0,
      REQ_DEP      = 3'd1,
      REQ_PASS     = 3'd2,
      REQ_PICK     = 3'd3,
      REQ_COMPLETE = 3'd4,
      REQ_RELEASE  = 3'd5,
      REQ_CLEAR    = 3'd6
   } req_kind_type;

   typedef struct packed {
      logic [REQ_W-1:0]    req_type;
      logic [TASK_W-1:0]   task_id;
      logic [TASK_W-1:0]   dep_id;
      logic                parent_valid;
      logic [TASK_W-1:0]   parent_id;
      logic                has_job;
      logic                affinity_valid;
      logic [WORKER_W-1:0] affinity;
      logic [WORKER_W-1:0] worker_id;
   } dtd_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [TASK_W-1:0]   task_id_res;
      logic [WORKER_W-1:0] worker_id_res;
      logic                last;
   } dtd_rsp_type;

   typedef struct packed {
      logic                has_job;
      logic                aff_valid;
      logic [WORKER_W-1:0] aff;
      logic                par_valid;
      logic [TASK_W-1:0]   par;
      logic                dep_valid;
      logic [TASK_W-1:0]   dep;
      logic [OC_W-1:0]     oc;
   } slot_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_ALLOC_RD,
      ST_ALLOC_WB,
      ST_DEP_RD,
      ST_DEP_WB,
      ST_COMP,
      ST_COMP_CHK,
      ST_LOW_RD,
      ST_LOW_WB,
      ST_REL,
      ST_CMP,
      ST_PICK_Q,
      ST_PICK_S,
      ST_PICK_CHK,
      ST_PICK_NEXT,
      ST_PASS_RD,
      ST_PASS_EV,
      ST_PASS_END,
      ST_CLEAR,
      ST_ACK
   } state_type;

endpackage
`default_nettype wire

### hw/rtl/dependency_aware_task_dispatcher.sv
// dependency-aware task dispatcher top level
//
// A request is taken when start is high and busy is low; busy then stays
// high until the last result of that request is on the rsp_ ports. Results
// come one per strobe cycle (rsp_valid) and the receiver cannot hold them
// off; rsp_payload.last marks the final one of a request.
// Slot fields live in a single-port-read slot memory, queue entries in a
// queue memory, both with registered reads; the sequencer reads an entry,
// then modifies and writes it back.
// A schedule pass walks every slot, reading each candidate and updating
// the parent of each task it chains. A pick reads queue entries in turn
// until one holds a task with no outstanding children, then compacts that
// queue. A release compacts every worker queue.
// Reset and clear empty the table and queues at once, no sweep needed.
// csr_ writes are taken only while busy is low.
`default_nettype none
module dependency_aware_task_dispatcher #(
   parameter int TASK_SLOTS = dtd_pkg::TASK_SLOTS_DEF,
   parameter int WORKERS    = dtd_pkg::WORKERS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  dtd_pkg::dtd_req_type              req_payload,
   output logic                              rsp_valid,
   output dtd_pkg::dtd_rsp_type              rsp_payload,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [dtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [dtd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int SIDX_W = $clog2(TASK_SLOTS);
   localparam int WIDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int TCNT_W = $clog2(TASK_SLOTS + 1);
   localparam int LEN_W  = $clog2(TASK_SLOTS + 1);
   localparam int WC_W   = $clog2(WORKERS + 1);
   localparam int QDEPTH = WORKERS * TASK_SLOTS;
   localparam int QA_W   = $clog2(QDEPTH);

   dtd_pkg::state_type state_ff, state_in;
   logic                busy_ff, busy_in;
   dtd_pkg::dtd_req_type req_ff, req_in;
   logic [TASK_SLOTS-1:0] used_ff, used_in, done_ff, done_in, asg_ff, asg_in;
   logic [LEN_W-1:0]    len_ff [WORKERS];
   logic [LEN_W-1:0]    len_in [WORKERS];
   logic [dtd_pkg::CNT_W-1:0] wcnt_ff, wcnt_in;
   logic [dtd_pkg::CAP_W-1:0] wcap_ff, wcap_in;
   logic [TCNT_W-1:0]   t_ff, t_in;
   logic [WIDX_W-1:0]   rr_ff, rr_in;
   logic [dtd_pkg::TASK_W-1:0] tgt_ff, tgt_in;
   logic [LEN_W-1:0]    qi_ff, qi_in, rd_ff, rd_in, wi_ff, wi_in, rdi_ff, rdi_in;
   logic                rdp_ff, rdp_in;
   logic [WIDX_W-1:0]   cw_ff, cw_in;
   logic                pend_v_ff, pend_v_in, rsp_v_ff, rsp_v_in;
   dtd_pkg::dtd_rsp_type pend_ff, pend_in, rsp_ff, rsp_in;

   logic                      s_clr, s_we, s_re;
   logic [SIDX_W-1:0]         s_waddr, s_raddr;
   dtd_pkg::slot_entry_type   s_wdata, s_rdata, s_mod;
   logic                      q_we, q_re;
   logic [QA_W-1:0]           q_waddr, q_raddr;
   logic [dtd_pkg::TASK_W-1:0] q_wdata, q_rdata;

   logic                emit, fin;
   dtd_pkg::dtd_rsp_type emit_res, fin_res;

   logic                free_found;
   logic [SIDX_W-1:0]   free_idx;
   logic [SIDX_W-1:0]   tix, rtix;
   logic                par_in_ok, task_ok, comp_go, rel_go;
   logic                dep_met, chain_go, rd_par_ok;
   logic                cmp_more, cmp_end, cmp_keep, cmp_last, pick_mode;
   logic                pick_wok, pick_more, pick_hit, pass_end, pass_cand;
   logic [WC_W-1:0]     wc_eff, rr_inc;
   logic                aff_hit, rr_full, alt_found;
   logic [WIDX_W-1:0]   alt_w, rr_sel, rr_next, push_w;

   function automatic logic [QA_W-1:0] qaddr(input logic [WIDX_W-1:0] w,
                                             input logic [LEN_W-1:0] i);
      return QA_W'(w) * QA_W'(TASK_SLOTS) + QA_W'(i);
   endfunction

   function automatic dtd_pkg::dtd_rsp_type mk(input logic [dtd_pkg::KIND_W-1:0] k,
                                               input logic [dtd_pkg::TASK_W-1:0] t,
                                               input logic [dtd_pkg::WORKER_W-1:0] w);
      dtd_pkg::dtd_rsp_type r;
      r.kind          = k;
      r.task_id_res   = t;
      r.worker_id_res = w;
      r.last          = 1'b0;
      return r;
   endfunction

   dtd_slot_mem #(.DEPTH(TASK_SLOTS), .AW(SIDX_W)) u_slot_mem (
      .clock (clock),
      .reset (reset),
      .clr   (s_clr),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   dtd_queue_mem #(.DEPTH(QDEPTH), .AW(QA_W)) u_queue_mem (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .re    (q_re),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SIDX_W'(i);
         end
      end
   end

   assign tix       = SIDX_W'(req_ff.task_id);
   assign rtix      = SIDX_W'(t_ff);
   assign par_in_ok = req_ff.parent_valid && (req_ff.parent_id < TASK_SLOTS);
   assign task_ok   = req_ff.task_id < TASK_SLOTS;
   assign comp_go   = task_ok && used_ff[tix] && !done_ff[tix];
   assign rel_go    = task_ok && used_ff[tix] && done_ff[tix];
   assign rd_par_ok = s_rdata.par_valid && (s_rdata.par < TASK_SLOTS);
   assign dep_met   = !s_rdata.dep_valid ||
                      ((s_rdata.dep < TASK_SLOTS) && done_ff[SIDX_W'(s_rdata.dep)]);
   assign chain_go  = !done_ff[rtix] && (s_rdata.oc == '0);
   assign pick_mode = req_ff.req_type == dtd_pkg::REQ_PICK;
   assign cmp_more  = rd_ff < len_ff[cw_ff];
   assign cmp_end   = !cmp_more && !rdp_ff;
   assign cmp_keep  = pick_mode ? (rdi_ff != qi_ff) : (q_rdata != req_ff.task_id);
   assign cmp_last  = cw_ff == WIDX_W'(WORKERS - 1);
   assign pick_wok  = req_ff.worker_id < WORKERS;
   assign pick_more = qi_ff < len_ff[cw_ff];
   assign pick_hit  = s_rdata.oc == '0;
   assign pass_end  = t_ff == TCNT_W'(TASK_SLOTS);
   assign pass_cand = used_ff[rtix] && !asg_ff[rtix];

   // worker choice for a schedule pass
   always_comb begin
      if (wcnt_ff == '0) begin
         wc_eff = WC_W'(1);
      end else if (wcnt_ff > WORKERS) begin
         wc_eff = WC_W'(WORKERS);
      end else begin
         wc_eff = WC_W'(wcnt_ff);
      end
      aff_hit   = s_rdata.aff_valid && (s_rdata.aff < wc_eff);
      rr_full   = 8'(len_ff[rr_ff]) >= 8'(wcap_ff);
      alt_found = 1'b0;
      alt_w     = '0;
      for (int w = WORKERS - 1; w >= 0; w--) begin
         if ((w < wc_eff) && (8'(len_ff[w]) < 8'(wcap_ff))) begin
            alt_found = 1'b1;
            alt_w     = WIDX_W'(w);
         end
      end
      rr_sel  = (rr_full && alt_found) ? alt_w : rr_ff;
      rr_inc  = WC_W'(rr_sel) + WC_W'(1);
      rr_next = (rr_inc == wc_eff) ? '0 : WIDX_W'(rr_inc);
      push_w  = aff_hit ? WIDX_W'(s_rdata.aff) : rr_sel;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtd_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_payload.req_type)
                  dtd_pkg::REQ_ALLOC:    state_in = dtd_pkg::ST_ALLOC;
                  dtd_pkg::REQ_DEP:      state_in = (req_payload.task_id < TASK_SLOTS) ?
                                                    dtd_pkg::ST_DEP_RD : dtd_pkg::ST_ACK;
                  dtd_pkg::REQ_PASS:     state_in = dtd_pkg::ST_PASS_RD;
                  dtd_pkg::REQ_PICK:     state_in = dtd_pkg::ST_PICK_Q;
                  dtd_pkg::REQ_COMPLETE: state_in = dtd_pkg::ST_COMP;
                  dtd_pkg::REQ_RELEASE:  state_in = dtd_pkg::ST_REL;
                  dtd_pkg::REQ_CLEAR:    state_in = dtd_pkg::ST_CLEAR;
                  default:               state_in = dtd_pkg::ST_ACK;
               endcase
            end
         end
         dtd_pkg::ST_ALLOC:
            state_in = (free_found && par_in_ok) ? dtd_pkg::ST_ALLOC_RD : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_ALLOC_RD: state_in = dtd_pkg::ST_ALLOC_WB;
         dtd_pkg::ST_ALLOC_WB: state_in = dtd_pkg::ST_IDLE;
         dtd_pkg::ST_DEP_RD:   state_in = dtd_pkg::ST_DEP_WB;
         dtd_pkg::ST_DEP_WB:   state_in = dtd_pkg::ST_IDLE;
         dtd_pkg::ST_COMP:
            state_in = comp_go ? dtd_pkg::ST_COMP_CHK : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_COMP_CHK:
            state_in = rd_par_ok ? dtd_pkg::ST_LOW_RD : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_LOW_RD:   state_in = dtd_pkg::ST_LOW_WB;
         dtd_pkg::ST_LOW_WB:
            state_in = (req_ff.req_type == dtd_pkg::REQ_PASS) ?
                       dtd_pkg::ST_PASS_RD : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_REL:
            state_in = rel_go ? dtd_pkg::ST_CMP : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_CMP: begin
            if (cmp_end) begin
               if (pick_mode) begin
                  state_in = dtd_pkg::ST_PICK_NEXT;
               end else if (cmp_last) begin
                  state_in = dtd_pkg::ST_IDLE;
               end
            end
         end
         dtd_pkg::ST_PICK_Q:
            state_in = (pick_wok && pick_more) ? dtd_pkg::ST_PICK_S : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_PICK_S:   state_in = dtd_pkg::ST_PICK_CHK;
         dtd_pkg::ST_PICK_CHK:
            state_in = pick_hit ? dtd_pkg::ST_CMP : dtd_pkg::ST_PICK_Q;
         dtd_pkg::ST_PICK_NEXT:
            state_in = done_ff[SIDX_W'(tgt_ff)] ? dtd_pkg::ST_PICK_Q : dtd_pkg::ST_IDLE;
         dtd_pkg::ST_PASS_RD: begin
            if (pass_end) begin
               state_in = dtd_pkg::ST_PASS_END;
            end else if (pass_cand) begin
               state_in = dtd_pkg::ST_PASS_EV;
            end
         end
         dtd_pkg::ST_PASS_EV:
            state_in = (dep_met && !s_rdata.has_job && chain_go && rd_par_ok) ?
                       dtd_pkg::ST_LOW_RD : dtd_pkg::ST_PASS_RD;
         dtd_pkg::ST_PASS_END: state_in = dtd_pkg::ST_IDLE;
         dtd_pkg::ST_CLEAR:    state_in = dtd_pkg::ST_IDLE;
         dtd_pkg::ST_ACK:      state_in = dtd_pkg::ST_IDLE;
         default:              state_in = dtd_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      busy_in   = busy_ff;
      req_in    = req_ff;
      used_in   = used_ff;
      done_in   = done_ff;
      asg_in    = asg_ff;
      len_in    = len_ff;
      wcnt_in   = wcnt_ff;
      wcap_in   = wcap_ff;
      t_in      = t_ff;
      rr_in     = rr_ff;
      tgt_in    = tgt_ff;
      qi_in     = qi_ff;
      rd_in     = rd_ff;
      wi_in     = wi_ff;
      rdi_in    = rdi_ff;
      rdp_in    = rdp_ff;
      cw_in     = cw_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      rsp_v_in  = 1'b0;
      rsp_in    = rsp_ff;
      s_clr     = 1'b0;
      s_we      = 1'b0;
      s_waddr   = '0;
      s_wdata   = '0;
      s_re      = 1'b0;
      s_raddr   = '0;
      s_mod     = s_rdata;
      q_we      = 1'b0;
      q_waddr   = '0;
      q_wdata   = '0;
      q_re      = 1'b0;
      q_raddr   = '0;
      emit      = 1'b0;
      emit_res  = '0;
      fin       = 1'b0;
      fin_res   = mk(dtd_pkg::RES_ACK, req_ff.task_id, '0);

      if (csr_valid && !busy_ff) begin
         priority case (csr_index)
            dtd_pkg::CSR_WORKER_COUNT:    wcnt_in = csr_data[dtd_pkg::CNT_W-1:0];
            dtd_pkg::CSR_WORKER_CAPACITY: wcap_in = csr_data[dtd_pkg::CAP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         dtd_pkg::ST_IDLE: begin
            if (start) begin
               busy_in = 1'b1;
               req_in  = req_payload;
               t_in    = '0;
               rr_in   = '0;
               qi_in   = '0;
               cw_in   = WIDX_W'(req_payload.worker_id);
            end
         end
         dtd_pkg::ST_ALLOC: begin
            if (free_found) begin
               s_we              = 1'b1;
               s_waddr           = free_idx;
               s_wdata.has_job   = req_ff.has_job;
               s_wdata.aff_valid = req_ff.affinity_valid;
               s_wdata.aff       = req_ff.affinity_valid ? req_ff.affinity : '0;
               s_wdata.par_valid = par_in_ok;
               s_wdata.par       = par_in_ok ? req_ff.parent_id : '0;
               used_in[free_idx] = 1'b1;
               done_in[free_idx] = 1'b0;
               asg_in[free_idx]  = 1'b0;
               tgt_in            = dtd_pkg::TASK_W'(free_idx);
               if (!par_in_ok) begin
                  fin     = 1'b1;
                  fin_res = mk(dtd_pkg::RES_ALLOCATED, dtd_pkg::TASK_W'(free_idx), '0);
               end
            end else begin
               fin     = 1'b1;
               fin_res = mk(dtd_pkg::RES_NO_SLOT, '0, '0);
            end
         end
         dtd_pkg::ST_ALLOC_RD: begin
            s_re    = 1'b1;
            s_raddr = SIDX_W'(req_ff.parent_id);
         end
         dtd_pkg::ST_ALLOC_WB: begin
            if (s_rdata.oc < dtd_pkg::OC_MAX) begin
               s_mod.oc = s_rdata.oc + 1'b1;
            end
            s_we    = 1'b1;
            s_waddr = SIDX_W'(req_ff.parent_id);
            s_wdata = s_mod;
            fin     = 1'b1;
            fin_res = mk(dtd_pkg::RES_ALLOCATED, tgt_ff, '0);
         end
         dtd_pkg::ST_DEP_RD: begin
            s_re    = 1'b1;
            s_raddr = tix;
         end
         dtd_pkg::ST_DEP_WB: begin
            s_mod.dep_valid = req_ff.dep_id < TASK_SLOTS;
            s_mod.dep       = (req_ff.dep_id < TASK_SLOTS) ? req_ff.dep_id : '0;
            s_we            = 1'b1;
            s_waddr         = tix;
            s_wdata         = s_mod;
            fin             = 1'b1;
         end
         dtd_pkg::ST_COMP: begin
            if (comp_go) begin
               done_in[tix] = 1'b1;
               s_re         = 1'b1;
               s_raddr      = tix;
            end else begin
               fin = 1'b1;
            end
         end
         dtd_pkg::ST_COMP_CHK: begin
            if (rd_par_ok) begin
               tgt_in = s_rdata.par;
            end else begin
               fin = 1'b1;
            end
         end
         dtd_pkg::ST_LOW_RD: begin
            s_re    = 1'b1;
            s_raddr = SIDX_W'(tgt_ff);
         end
         dtd_pkg::ST_LOW_WB: begin
            if (s_rdata.oc != '0) begin
               s_mod.oc = s_rdata.oc - 1'b1;
               s_we     = 1'b1;
               s_waddr  = SIDX_W'(tgt_ff);
               s_wdata  = s_mod;
            end
            if (req_ff.req_type == dtd_pkg::REQ_PASS) begin
               t_in = t_ff + TCNT_W'(1);
            end else begin
               fin = 1'b1;
            end
         end
         dtd_pkg::ST_REL: begin
            if (rel_go) begin
               used_in[tix] = 1'b0;
               cw_in        = '0;
               rd_in        = '0;
               wi_in        = '0;
               rdp_in       = 1'b0;
            end else begin
               fin     = 1'b1;
               fin_res = mk(dtd_pkg::RES_REFUSED, req_ff.task_id, '0);
            end
         end
         dtd_pkg::ST_CMP: begin
            rdp_in = cmp_more;
            if (cmp_more) begin
               q_re    = 1'b1;
               q_raddr = qaddr(cw_ff, rd_ff);
               rd_in   = rd_ff + LEN_W'(1);
               rdi_in  = rd_ff;
            end
            if (rdp_ff && cmp_keep) begin
               q_we    = 1'b1;
               q_waddr = qaddr(cw_ff, wi_ff);
               q_wdata = q_rdata;
               wi_in   = wi_ff + LEN_W'(1);
            end
            if (cmp_end) begin
               len_in[cw_ff] = wi_ff;
               if (!pick_mode) begin
                  if (cmp_last) begin
                     fin = 1'b1;
                  end else begin
                     cw_in = cw_ff + WIDX_W'(1);
                     rd_in = '0;
                     wi_in = '0;
                  end
               end
            end
         end
         dtd_pkg::ST_PICK_Q: begin
            if (pick_wok && pick_more) begin
               q_re    = 1'b1;
               q_raddr = qaddr(cw_ff, qi_ff);
            end else begin
               fin     = 1'b1;
               fin_res = mk(dtd_pkg::RES_NONE, '0, req_ff.worker_id);
            end
         end
         dtd_pkg::ST_PICK_S: begin
            s_re    = 1'b1;
            s_raddr = SIDX_W'(q_rdata);
            tgt_in  = q_rdata;
         end
         dtd_pkg::ST_PICK_CHK: begin
            if (pick_hit) begin
               rd_in  = qi_ff;
               wi_in  = qi_ff;
               rdp_in = 1'b0;
            end else begin
               qi_in = qi_ff + LEN_W'(1);
            end
         end
         dtd_pkg::ST_PICK_NEXT: begin
            if (!done_ff[SIDX_W'(tgt_ff)]) begin
               fin     = 1'b1;
               fin_res = mk(dtd_pkg::RES_PICKED, tgt_ff, req_ff.worker_id);
            end
         end
         dtd_pkg::ST_PASS_RD: begin
            if (!pass_end) begin
               if (pass_cand) begin
                  s_re    = 1'b1;
                  s_raddr = rtix;
               end else begin
                  t_in = t_ff + TCNT_W'(1);
               end
            end
         end
         dtd_pkg::ST_PASS_EV: begin
            t_in = t_ff + TCNT_W'(1);
            if (dep_met) begin
               if (!s_rdata.has_job) begin
                  if (chain_go) begin
                     done_in[rtix] = 1'b1;
                     emit          = 1'b1;
                     emit_res      = mk(dtd_pkg::RES_CHAIN, dtd_pkg::TASK_W'(t_ff), '0);
                     if (rd_par_ok) begin
                        tgt_in = s_rdata.par;
                        t_in   = t_ff;
                     end
                  end
               end else begin
                  asg_in[rtix] = 1'b1;
                  if (len_ff[push_w] < TASK_SLOTS) begin
                     q_we           = 1'b1;
                     q_waddr        = qaddr(push_w, len_ff[push_w]);
                     q_wdata        = dtd_pkg::TASK_W'(t_ff);
                     len_in[push_w] = len_ff[push_w] + LEN_W'(1);
                  end
                  emit     = 1'b1;
                  emit_res = mk(dtd_pkg::RES_ASSIGNED, dtd_pkg::TASK_W'(t_ff),
                                dtd_pkg::WORKER_W'(push_w));
                  if (!aff_hit) begin
                     rr_in = rr_next;
                  end
               end
            end
         end
         dtd_pkg::ST_PASS_END: begin
            fin     = 1'b1;
            fin_res = mk(dtd_pkg::RES_PASS_END, '0, '0);
         end
         dtd_pkg::ST_CLEAR: begin
            used_in = '0;
            done_in = '0;
            asg_in  = '0;
            for (int w = 0; w < WORKERS; w++) begin
               len_in[w] = '0;
            end
            s_clr   = 1'b1;
            fin     = 1'b1;
            fin_res = mk(dtd_pkg::RES_ACK, '0, '0);
         end
         dtd_pkg::ST_ACK: begin
            fin = 1'b1;
         end
         default: ;
      endcase

      // one result held back so the final one can carry last
      if (emit) begin
         if (pend_v_ff) begin
            rsp_v_in = 1'b1;
            rsp_in   = pend_ff;
         end
         pend_in   = emit_res;
         pend_v_in = 1'b1;
      end
      if (fin) begin
         rsp_v_in    = 1'b1;
         rsp_in      = pend_v_ff ? pend_ff : fin_res;
         rsp_in.last = 1'b1;
         pend_v_in   = 1'b0;
         busy_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dtd_pkg::ST_IDLE;
         busy_ff   <= 1'b0;
         used_ff   <= '0;
         done_ff   <= '0;
         asg_ff    <= '0;
         wcnt_ff   <= dtd_pkg::WCNT_RST;
         wcap_ff   <= dtd_pkg::WCAP_RST;
         rdp_ff    <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int w = 0; w < WORKERS; w++) begin
            len_ff[w] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         used_ff   <= used_in;
         done_ff   <= done_in;
         asg_ff    <= asg_in;
         wcnt_ff   <= wcnt_in;
         wcap_ff   <= wcap_in;
         rdp_ff    <= rdp_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      t_ff    <= t_in;
      rr_ff   <= rr_in;
      tgt_ff  <= tgt_in;
      qi_ff   <= qi_in;
      rd_ff   <= rd_in;
      wi_ff   <= wi_in;
      rdi_ff  <= rdi_in;
      cw_ff   <= cw_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign busy        = busy_ff;
   assign csr_ready   = !busy_ff;
   assign rsp_valid   = rsp_v_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

### hw/rtl/dtd_slot_mem.sv
// task slot table memory with per-row valid bits
`default_nettype none
module dtd_slot_mem #(
   parameter int DEPTH = dtd_pkg::TASK_SLOTS_DEF,
   parameter int AW    = $clog2(dtd_pkg::TASK_SLOTS_DEF)
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         clr,
   input  wire                         we,
   input  wire [AW-1:0]                waddr,
   input  dtd_pkg::slot_entry_type     wdata,
   input  wire                         re,
   input  wire [AW-1:0]                raddr,
   output dtd_pkg::slot_entry_type     rdata
);

   dtd_pkg::slot_entry_type mem_ff [DEPTH];
   dtd_pkg::slot_entry_type rd_ff;
   logic [DEPTH-1:0]        valid_ff;
   logic                    rv_ff;

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem_ff[raddr];
         rv_ff <= valid_ff[raddr];
      end
   end

   assign rdata = rv_ff ? rd_ff : '0;

endmodule
`default_nettype wire

### hw/rtl/dtd_queue_mem.sv
// per-worker queue storage
`default_nettype none
module dtd_queue_mem #(
   parameter int DEPTH = dtd_pkg::TASK_SLOTS_DEF * dtd_pkg::WORKERS_DEF,
   parameter int AW    = $clog2(dtd_pkg::TASK_SLOTS_DEF * dtd_pkg::WORKERS_DEF)
) (
   input  wire                        clock,
   input  wire                        we,
   input  wire [AW-1:0]               waddr,
   input  wire [dtd_pkg::TASK_W-1:0]  wdata,
   input  wire                        re,
   input  wire [AW-1:0]               raddr,
   output logic [dtd_pkg::TASK_W-1:0] rdata
);

   logic [dtd_pkg::TASK_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/dtd_checker.sv
// port-level checks for the task dispatcher, bound to the top level
`default_nettype none
module dtd_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input dtd_pkg::dtd_req_type          req_payload,
   input wire                           rsp_valid,
   input dtd_pkg::dtd_rsp_type          rsp_payload,
   input wire                           csr_valid,
   input wire                           csr_ready,
   input wire [dtd_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire [dtd_pkg::CSR_DATA_W-1:0] csr_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |-> !busy)
      else $error("busy still high with final result");

   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_valid || rsp_payload.last)
      else $error("non-final result while idle");

   a_rise_quiet: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> !rsp_valid)
      else $error("result on first busy cycle");

endmodule

bind dependency_aware_task_dispatcher dtd_checker u_dtd_checker (.*);
`default_nettype wire

### verif/dependency_aware_task_dispatcher_tb.sv
// testbench for the dependency-aware task dispatcher: directed and random requests checked
// against a behavioral scoreboard
`timescale 1ns / 1ps
module dependency_aware_task_dispatcher_tb;
   import dtd_pkg::*;

   localparam int NSLOT = 32;
   localparam int NWORK = 8;
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 27;

   class dispatch_scoreboard;
      bit used[NSLOT], done[NSLOT], asg[NSLOT], job[NSLOT];
      bit affv[NSLOT], parv[NSLOT], depv[NSLOT];
      bit [WORKER_W-1:0] aff[NSLOT];
      bit [TASK_W-1:0] par[NSLOT], dep[NSLOT];
      bit [OC_W-1:0] oc[NSLOT];
      bit [TASK_W-1:0] wq[NWORK][$];
      int unsigned wcount = 8, wcap = 4;
      dtd_rsp_type outcomes[$];

      function void clear_table();
         foreach (used[i]) begin
            used[i] = 0; done[i] = 0; asg[i] = 0; job[i] = 0; affv[i] = 0;
            parv[i] = 0; depv[i] = 0; aff[i] = 0; par[i] = 0; dep[i] = 0; oc[i] = 0;
         end
         foreach (wq[w]) wq[w].delete();
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         if (idx == CSR_WORKER_COUNT) wcount = v[3:0];
         else if (idx == CSR_WORKER_CAPACITY) wcap = v[5:0];
      endfunction

      function void emit(logic [KIND_W-1:0] k, int t, int w);
         dtd_rsp_type r;
         r.kind = k;
         r.task_id_res = t[TASK_W-1:0];
         r.worker_id_res = w[WORKER_W-1:0];
         r.last = 1'b0;
         outcomes.push_back(r);
      endfunction

      function void lower_parent(int t);
         if (parv[t] && oc[par[t]] != 0) oc[par[t]]--;
      endfunction

      function void schedule_pass();
         int n, rr, wc, target;
         n = 0; rr = 0;
         wc = (wcount == 0) ? 1 : (wcount > NWORK) ? NWORK : wcount;
         for (int t = 0; t < NSLOT; t++) begin
            if (!used[t] || asg[t] || (depv[t] && !done[dep[t]])) continue;
            if (!job[t]) begin
               if (!done[t] && oc[t] == 0) begin
                  done[t] = 1;
                  lower_parent(t);
                  emit(RES_CHAIN, t, 0);
                  n++;
               end
               continue;
            end
            if (affv[t] && aff[t] < wc) target = aff[t];
            else begin
               if (wq[rr].size() >= wcap)
                  for (int w = 0; w < wc; w++)
                     if (wq[w].size() < wcap) begin
                        rr = w;
                        break;
                     end
               target = rr;
               rr = (rr + 1) % wc;
            end
            asg[t] = 1;
            if (wq[target].size() < NSLOT) wq[target].push_back(t);
            emit(RES_ASSIGNED, t, target);
            n++;
         end
         if (n == 0) emit(RES_PASS_END, 0, 0);
      endfunction

      function void worker_pick(int w);
         int idx, t;
         forever begin
            idx = -1;
            foreach (wq[w][i])
               if (oc[wq[w][i]] == 0) begin
                  idx = i;
                  break;
               end
            if (idx < 0) begin
               emit(RES_NONE, 0, w);
               return;
            end
            t = wq[w][idx];
            wq[w].delete(idx);
            if (!done[t]) begin
               emit(RES_PICKED, t, w);
               return;
            end
         end
      endfunction

      function void note_request(dtd_req_type r);
         int s;
         case (r.req_type)
            REQ_ALLOC: begin
               s = -1;
               for (int i = 0; i < NSLOT; i++)
                  if (!used[i]) begin
                     s = i;
                     break;
                  end
               if (s < 0) emit(RES_NO_SLOT, 0, 0);
               else begin
                  used[s] = 1; done[s] = 0; asg[s] = 0; job[s] = r.has_job;
                  affv[s] = r.affinity_valid; aff[s] = r.affinity_valid ? r.affinity : 0;
                  depv[s] = 0; dep[s] = 0; oc[s] = 0;
                  parv[s] = r.parent_valid; par[s] = r.parent_valid ? r.parent_id : 0;
                  if (r.parent_valid && oc[r.parent_id] < OC_MAX) oc[r.parent_id]++;
                  emit(RES_ALLOCATED, s, 0);
               end
            end
            REQ_DEP: begin
               depv[r.task_id] = 1;
               dep[r.task_id] = r.dep_id;
               emit(RES_ACK, r.task_id, 0);
            end
            REQ_PASS: schedule_pass();
            REQ_PICK: worker_pick(r.worker_id);
            REQ_COMPLETE: begin
               if (used[r.task_id] && !done[r.task_id]) begin
                  done[r.task_id] = 1;
                  lower_parent(r.task_id);
               end
               emit(RES_ACK, r.task_id, 0);
            end
            REQ_RELEASE: begin
               if (used[r.task_id] && done[r.task_id]) begin
                  used[r.task_id] = 0;
                  foreach (wq[w])
                     for (int i = wq[w].size() - 1; i >= 0; i--)
                        if (wq[w][i] == r.task_id) wq[w].delete(i);
                  emit(RES_ACK, r.task_id, 0);
               end else emit(RES_REFUSED, r.task_id, 0);
            end
            REQ_CLEAR: begin
               clear_table();
               emit(RES_ACK, 0, 0);
            end
            default: emit(RES_ACK, r.task_id, 0);
         endcase
         outcomes[outcomes.size() - 1].last = 1'b1;
      endfunction

      function string check_result(dtd_rsp_type got);
         dtd_rsp_type want;
         string msg;
         if (outcomes.size() == 0) return $sformatf("unexpected result %p", got);
         want = outcomes.pop_front();
         msg = "";
         if (got.kind != want.kind)
            msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
         if (got.task_id_res != want.task_id_res)
            msg = {msg, $sformatf(" task %0d/%0d", got.task_id_res, want.task_id_res)};
         if (got.worker_id_res != want.worker_id_res)
            msg = {msg, $sformatf(" worker %0d/%0d", got.worker_id_res, want.worker_id_res)};
         if (got.last != want.last)
            msg = {msg, $sformatf(" last %0d/%0d", got.last, want.last)};
         return msg;
      endfunction
   endclass

   logic clock = 0, reset = 1, start = 0, csr_valid = 0;
   logic busy, rsp_valid, csr_ready;
   dtd_req_type req_payload = '0;
   dtd_rsp_type rsp_payload;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   dispatch_scoreboard tracker = new();
   int failures = 0, stall_cycles = 0, idle_pct = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   dependency_aware_task_dispatcher uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   task report(string msg);
      $display("mismatch at %0t:%s", $realtime, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         stall_cycles++;
         if (start && !busy) begin
            tracker.note_request(req_payload);
            stall_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            tracker.set_reg(csr_index, csr_data);
            stall_cycles = 0;
         end
         if (rsp_valid) begin
            msg = tracker.check_result(rsp_payload);
            if (msg != "") report(msg);
            stall_cycles = 0;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task send(dtd_req_type r);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.outcomes.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic dtd_req_type mk(req_kind_type k, int t, int d, bit pv, int pid,
                                       bit hj, bit av, int af, int w);
      dtd_req_type r;
      r.req_type = k; r.task_id = t; r.dep_id = d; r.parent_valid = pv;
      r.parent_id = pid; r.has_job = hj; r.affinity_valid = av; r.affinity = af;
      r.worker_id = w;
      return r;
   endfunction

   function automatic dtd_req_type random_request(int alloc_pct);
      dtd_req_type r;
      int roll;
      r = dtd_req_type'({$urandom, $urandom});
      roll = $urandom_range(99);
      if (roll < alloc_pct) r.req_type = REQ_ALLOC;
      else if (roll < alloc_pct + 8) r.req_type = REQ_DEP;
      else if (roll < alloc_pct + 23) r.req_type = REQ_PASS;
      else if (roll < alloc_pct + 40) r.req_type = REQ_PICK;
      else if (roll < alloc_pct + 57) r.req_type = REQ_COMPLETE;
      else if (roll < alloc_pct + 70) r.req_type = REQ_RELEASE;
      else if (roll < alloc_pct + 72) r.req_type = REQ_CLEAR;
      else if (roll < alloc_pct + 74) r.req_type = 3'd7;
      else r.req_type = REQ_ALLOC;
      if ($urandom_range(99) < 80) begin
         r.task_id = $urandom_range(0, 11);
         r.dep_id = $urandom_range(0, 11);
         r.parent_id = $urandom_range(0, 11);
      end
      if ($urandom_range(99) < 60) r.parent_valid = 1'b0;
      return r;
   endfunction

   initial begin
      int wcounts[6] = '{8, 1, 0, 3, 15, 5};
      int wcaps[6] = '{4, 1, 0, 32, 63, 2};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send(mk(REQ_ALLOC, 0, 0, 0, 0, 1, 1, 7, 0));
      send(mk(REQ_ALLOC, 0, 0, 1, 0, 0, 0, 0, 0));
      send(mk(REQ_ALLOC, 0, 0, 1, 2, 0, 0, 0, 0));
      send(mk(REQ_ALLOC, 0, 0, 1, 31, 1, 1, 2, 0));
      send(mk(REQ_DEP, 3, 1, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_DEP, 31, 31, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_PASS, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 7));
      send(mk(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_RELEASE, 2, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_PASS, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_COMPLETE, 2, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_ALLOC, 0, 0, 0, 0, 1, 0, 0, 0));
      send(mk(REQ_PASS, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 2));
      send(mk(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 0));
      send(mk(req_kind_type'(3'd7), 31, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_CLEAR, 5, 0, 0, 0, 0, 0, 0, 0));
      send(mk(REQ_PICK, 0, 0, 0, 0, 0, 0, 0, 3));
      send(mk(REQ_PASS, 0, 0, 0, 0, 0, 0, 0, 0));

      for (int p = 0; p < 6; p++) begin
         drain();
         write_reg(CSR_WORKER_COUNT, wcounts[p]);
         write_reg(CSR_WORKER_CAPACITY, wcaps[p]);
         case (p % 4)
            1: idle_pct = 59;
            2: idle_pct = 12;
            default: idle_pct = 0;
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send(random_request(p == 3 ? 60 : 26));
      end

      drain();
      repeat (40) @(posedge clock);
      if (failures == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
